@@ rtl/core/ctdh_pkg.sv @@
// ----------------------------------------------------------------------------
// Coincidence time-difference histogram package
// Shared widths, sizes, limits and a helper function of the histogram unit.
// ----------------------------------------------------------------------------
package ctdh_pkg;

    localparam int HIST_BINS    = 32768;
    localparam int BIN_W        = $clog2(HIST_BINS);
    localparam int WINDOW_SLOTS = 64;
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS);

    localparam int TS_W       = 64;
    localparam int WINDOW_W   = 32;
    localparam int COUNT_W    = 32;
    localparam int FIT_W      = 8;
    localparam int READ_BIN_W = 15;

    localparam logic [FIT_W-1:0]    FIT_QUALIFY  = FIT_W'(1);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(1000);
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    localparam logic ACTION_FRAGMENT = 1'b0;
    localparam logic ACTION_READ     = 1'b1;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [SLOT_W-1:0] lowest_one(input logic [WINDOW_SLOTS-1:0] v);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/ctdh_if.sv @@
// ----------------------------------------------------------------------------
// Histogram unit channels
// Valid/ready channels for incoming words and for result words.
// ----------------------------------------------------------------------------
interface ctdh_frag_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [ctdh_pkg::TS_W-1:0]        timestamp_ns;
    logic                             in_detector;
    logic [ctdh_pkg::FIT_W-1:0]       fit_type;
    logic [ctdh_pkg::READ_BIN_W-1:0]  read_bin;

    modport source (output valid, action, timestamp_ns, in_detector, fit_type, read_bin,
                    input ready);
    modport sink   (input valid, action, timestamp_ns, in_detector, fit_type, read_bin,
                    output ready);
endinterface

interface ctdh_result_if;
    logic                           valid;
    logic                           ready;
    logic [ctdh_pkg::COUNT_W-1:0]   bin_count;
    logic                           slots_overflowed;

    modport source (output valid, bin_count, slots_overflowed, input ready);
    modport sink   (input valid, bin_count, slots_overflowed, output ready);
endinterface

@@ rtl/core/coincidence_time_difference_histogram_unit.sv @@
// ----------------------------------------------------------------------------
// Coincidence time-difference histogram unit
// Keeps a window of stored qualifying fragments and histograms the time
// differences to each new qualifying fragment in a saturating bin memory.
// ----------------------------------------------------------------------------
// Read word: S_READ, then S_REPLY registers the result once no earlier result
// is stalled, and the next word can then be taken. Fragment word: S_PICK,
// S_DIFF, S_CHECK per live slot, S_BUMP (single-port bin read-modify-write)
// for each slot that bumps a bin, a last S_PICK, S_PLACE if it qualifies.
// After reset a clearing pass zeroes all 32768 bins, one per cycle, before
// the first word is taken; configuration writes are taken during it.
module coincidence_time_difference_histogram_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    ctdh_frag_if.sink                        frag,
    ctdh_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [ctdh_pkg::WINDOW_W-1:0]    cfg_wdata
);
    import ctdh_pkg::*;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_PICK  = 9'b000000100,
        S_DIFF  = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_BUMP  = 9'b000100000,
        S_PLACE = 9'b001000000,
        S_READ  = 9'b010000000,
        S_REPLY = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [WINDOW_W-1:0]     window_reg;
    logic [BIN_W-1:0]        clr_cnt_reg;
    logic [WINDOW_SLOTS-1:0] slot_valid_reg;
    logic [WINDOW_SLOTS-1:0] pend_reg;
    logic                    ovf_reg;

    logic [TS_W-1:0]         ts_reg;
    logic                    qual_reg;
    logic [BIN_W-1:0]        rd_idx_reg;
    logic                    rd_oob_reg;
    logic [SLOT_W-1:0]       k_reg;
    logic [TS_W-1:0]         d_reg;

    logic                    res_valid_reg;
    logic [COUNT_W-1:0]      res_count_reg;
    logic                    res_ovf_reg;

    logic [TS_W-1:0]         slot_mem [WINDOW_SLOTS];
    logic [TS_W-1:0]         slot_rdata_reg;
    logic [COUNT_W-1:0]      bin_mem [HIST_BINS];
    logic [COUNT_W-1:0]      bin_rdata_reg;

    logic                    accept;
    logic [SLOT_W-1:0]       pick_idx;
    logic [SLOT_W-1:0]       free_idx;
    logic                    d_outside;
    logic                    d_in_bins;
    logic                    res_load;

    logic [BIN_W-1:0]        bin_addr;
    logic                    bin_we;
    logic [COUNT_W-1:0]      bin_wdata;

    assign frag.ready = (state_reg == S_IDLE);
    assign accept     = frag.valid && frag.ready;
    assign pick_idx   = lowest_one(pend_reg);
    assign free_idx   = lowest_one(~slot_valid_reg);
    assign d_outside  = (d_reg[TS_W-1:WINDOW_W] != '0) || (d_reg[WINDOW_W-1:0] > window_reg);
    assign d_in_bins  = (d_reg[TS_W-1:BIN_W] == '0);
    assign res_load   = (state_reg == S_REPLY) && (!res_valid_reg || result.ready);

    assign result.valid            = res_valid_reg;
    assign result.bin_count        = res_count_reg;
    assign result.slots_overflowed = res_ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == BIN_W'(HIST_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (frag.action == ACTION_READ) ? S_READ : S_PICK;
                end
            end
            S_PICK:
            begin
                if (pend_reg == '0)
                begin
                    state_next = qual_reg ? S_PLACE : S_IDLE;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:  state_next = S_CHECK;
            S_CHECK:
            begin
                if (!d_outside && qual_reg && d_in_bins)
                begin
                    state_next = S_BUMP;
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_BUMP:  state_next = S_PICK;
            S_PLACE: state_next = S_IDLE;
            S_READ:  state_next = S_REPLY;
            S_REPLY:
            begin
                if (res_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The bin memory has one port; every access is in a state of its own.
    // While a reply waits, the read address stays on the requested bin.
    always_comb
    begin
        bin_addr  = d_reg[BIN_W-1:0];
        bin_we    = 1'b0;
        bin_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                bin_addr = clr_cnt_reg;
                bin_we   = 1'b1;
            end
            S_READ:  bin_addr = rd_idx_reg;
            S_REPLY: bin_addr = rd_idx_reg;
            S_BUMP:
            begin
                bin_we    = 1'b1;
                bin_wdata = (bin_rdata_reg == COUNT_MAX) ? bin_rdata_reg
                                                         : bin_rdata_reg + COUNT_W'(1);
            end
            default: bin_addr = d_reg[BIN_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_addr] <= bin_wdata;
        end
        bin_rdata_reg <= bin_mem[bin_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PLACE && !(&slot_valid_reg))
        begin
            slot_mem[free_idx] <= ts_reg;
        end
        slot_rdata_reg <= slot_mem[pick_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            window_reg     <= WINDOW_RESET;
            clr_cnt_reg    <= '0;
            slot_valid_reg <= '0;
            pend_reg       <= '0;
            ovf_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + BIN_W'(1);
            end
            if (accept)
            begin
                pend_reg <= slot_valid_reg;
            end
            else if (state_reg == S_PICK)
            begin
                pend_reg[pick_idx] <= 1'b0;
            end
            if (state_reg == S_CHECK && d_outside)
            begin
                slot_valid_reg[k_reg] <= 1'b0;
            end
            if (state_reg == S_PLACE)
            begin
                if (&slot_valid_reg)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    slot_valid_reg[free_idx] <= 1'b1;
                end
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg     <= frag.timestamp_ns;
            qual_reg   <= frag.in_detector && (frag.fit_type == FIT_QUALIFY);
            rd_idx_reg <= BIN_W'(frag.read_bin);
            rd_oob_reg <= (32'(frag.read_bin) >= 32'(HIST_BINS));
        end
        if (state_reg == S_PICK)
        begin
            k_reg <= pick_idx;
        end
        if (state_reg == S_DIFF)
        begin
            d_reg <= ts_reg - slot_rdata_reg;
        end
        if (res_load)
        begin
            res_count_reg <= rd_oob_reg ? '0 : bin_rdata_reg;
            res_ovf_reg   <= ovf_reg;
        end
    end

endmodule

@@ rtl/core/ctdh_checker.sv @@
// ----------------------------------------------------------------------------
// Histogram unit port checker
// Watches the ports of the histogram unit for handshake and reply rules.
// ----------------------------------------------------------------------------
module ctdh_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           frag_valid,
    input logic                           frag_ready,
    input logic                           frag_action,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [ctdh_pkg::COUNT_W-1:0]   res_bin_count,
    input logic                           res_slots_overflowed
);
    import ctdh_pkg::*;

    logic [1:0] pending_reg;
    logic       seen_ovf_reg;
    logic       rd_take;
    logic       res_take;

    assign rd_take  = frag_valid && frag_ready && (frag_action == ACTION_READ);
    assign res_take = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= '0;
            seen_ovf_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(rd_take) - 2'(res_take);
            if (res_take && res_slots_overflowed)
            begin
                seen_ovf_reg <= 1'b1;
            end
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_bin_count))
        else $error("result word dropped or changed while stalled");

    a_res_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("result word without an outstanding read");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more reads outstanding than the unit can hold");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && seen_ovf_reg |-> res_slots_overflowed)
        else $error("slot overflow flag cleared without reset");

endmodule

bind coincidence_time_difference_histogram_unit ctdh_checker u_ctdh_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .frag_valid           (frag.valid),
    .frag_ready           (frag.ready),
    .frag_action          (frag.action),
    .res_valid            (result.valid),
    .res_ready            (result.ready),
    .res_bin_count        (result.bin_count),
    .res_slots_overflowed (result.slots_overflowed)
);

@@ bench/ctdh_histogram_checker.sv @@
// ----------------------------------------------------------------------------
// Histogram unit result checker
// Watches the fragment, result and configuration ports, keeps its own copy of
// the window slots and bin memory, and compares every read word with the
// count and overflow flag that it expects.
// ----------------------------------------------------------------------------
module ctdh_histogram_checker
    import ctdh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ctdh_frag_if                frag,
    ctdh_result_if              result,
    input  logic                cfg_we,
    input  logic [WINDOW_W-1:0] cfg_wdata,
    output int                  mismatches,
    output int                  reads_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COUNT_W-1:0] bin_count;
        logic               slots_overflowed;
    } bin_answer_t;

    logic [TS_W-1:0]         slot_stamp [WINDOW_SLOTS];
    logic [WINDOW_SLOTS-1:0] slot_live;
    logic [COUNT_W-1:0]      hist [HIST_BINS];
    logic                    overflow_seen;
    logic [WINDOW_W-1:0]     window_ns;
    bin_answer_t             pending_answers [$];
    int                      error_total;

    initial
    begin
        mismatches    = 0;
        reads_waiting = 0;
        error_total   = 0;
    end

    // All live slots are compared and retired first; only then is a
    // qualifying fragment placed in the lowest free slot.
    function automatic void take_fragment(input logic [TS_W-1:0] stamp, input logic det,
                                          input logic [FIT_W-1:0] fit);
        logic             qualifies;
        logic [TS_W-1:0]  diff;
        logic [BIN_W-1:0] bin_idx;
        int               free_slot;
        qualifies = det && (fit == FIT_QUALIFY);
        for (int k = 0; k < WINDOW_SLOTS; k++)
        begin
            if (slot_live[k])
            begin
                diff    = stamp - slot_stamp[k];
                bin_idx = diff[BIN_W-1:0];
                if (diff > {{(TS_W-WINDOW_W){1'b0}}, window_ns})
                begin
                    slot_live[k] = 1'b0;
                end
                else if (qualifies && diff < TS_W'(HIST_BINS))
                begin
                    if (hist[bin_idx] != COUNT_MAX)
                    begin
                        hist[bin_idx] = hist[bin_idx] + COUNT_W'(1);
                    end
                end
            end
        end
        if (qualifies)
        begin
            free_slot = -1;
            for (int k = 0; k < WINDOW_SLOTS && free_slot < 0; k++)
            begin
                if (!slot_live[k])
                begin
                    free_slot = k;
                end
            end
            if (free_slot < 0)
            begin
                overflow_seen = 1'b1;
            end
            else
            begin
                slot_live[free_slot]  = 1'b1;
                slot_stamp[free_slot] = stamp;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bin_answer_t want;
        if (!rst_n)
        begin
            for (int b = 0; b < HIST_BINS; b++)
            begin
                hist[b] = '0;
            end
            slot_live     = '0;
            overflow_seen = 1'b0;
            window_ns     = WINDOW_RESET;
            pending_answers.delete();
        end
        else
        begin
            // A result can never belong to a read taken at the same edge, so
            // the result side is handled before the input side.
            if (result.valid && result.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    error_total++;
                    $display("%0t: unexpected result word: bin_count %0d overflow %0b",
                             $time, result.bin_count, result.slots_overflowed);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (result.bin_count !== want.bin_count)
                    begin
                        error_total++;
                        $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                                 $time, want.bin_count, result.bin_count);
                    end
                    if (result.slots_overflowed !== want.slots_overflowed)
                    begin
                        error_total++;
                        $display("%0t: slots_overflowed mismatch: expected %0b, actual %0b",
                                 $time, want.slots_overflowed, result.slots_overflowed);
                    end
                end
            end
            if (cfg_we)
            begin
                window_ns = cfg_wdata;
            end
            if (frag.valid && frag.ready)
            begin
                if (frag.action == ACTION_READ)
                begin
                    want.bin_count = '0;
                    if (int'(frag.read_bin) < HIST_BINS)
                    begin
                        want.bin_count = hist[frag.read_bin];
                    end
                    want.slots_overflowed = overflow_seen;
                    pending_answers.push_back(want);
                end
                else
                begin
                    take_fragment(frag.timestamp_ns, frag.in_detector, frag.fit_type);
                end
            end
        end
        mismatches    <= error_total;
        reads_waiting <= pending_answers.size();
    end

endmodule

@@ bench/coincidence_time_difference_histogram_unit_test.sv @@
// ----------------------------------------------------------------------------
// Histogram unit testbench
// Drives fragment and read words into the histogram unit under random stalls
// on both channels, moves the coincidence window through several settings,
// and leaves prediction and comparison to the attached checker.
// ----------------------------------------------------------------------------
module coincidence_time_difference_histogram_unit_test;
    import ctdh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Covers the longest fragment word, which visits every live slot, with margin.
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 400;
    // The clearing pass after reset runs without any handshake.
    localparam int WATCHDOG_LIMIT = 100000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [WINDOW_W-1:0] cfg_wdata;
    int                  mismatches;
    int                  reads_waiting;
    int                  fragments_sent;
    int                  reads_sent;
    int                  windows_used;
    int                  quiet_cycles;
    bit                  gaps_on;
    bit                  no_idle;
    bit                  hold_req;

    ctdh_frag_if   frag_ch ();
    ctdh_result_if result_ch ();

    coincidence_time_difference_histogram_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frag      (frag_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ctdh_histogram_checker hist_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .frag          (frag_ch),
        .result        (result_ch),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .reads_waiting (reads_waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Result side: short random stalls, and one long hold on request.
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((frag_ch.valid && frag_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [TS_W-1:0] stamp, input logic det,
                             input logic [FIT_W-1:0] fit, input logic [READ_BIN_W-1:0] bin);
        if (gaps_on && !no_idle && $urandom_range(0, 3) == 0)
        begin
            frag_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        frag_ch.valid        <= 1'b1;
        frag_ch.action       <= act;
        frag_ch.timestamp_ns <= stamp;
        frag_ch.in_detector  <= det;
        frag_ch.fit_type     <= fit;
        frag_ch.read_bin     <= bin;
        do
        begin
            @(posedge clk);
        end
        while (frag_ch.ready !== 1'b1);
        if (act == ACTION_READ)
        begin
            reads_sent++;
        end
        else
        begin
            fragments_sent++;
        end
    endtask

    task automatic send_fragment(input logic [TS_W-1:0] stamp, input logic det,
                                 input logic [FIT_W-1:0] fit);
        send_word(ACTION_FRAGMENT, stamp, det, fit, READ_BIN_W'($urandom));
    endtask

    // The fragment fields of a read word are ignored, so they carry noise.
    task automatic send_read(input logic [READ_BIN_W-1:0] bin);
        send_word(ACTION_READ, {$urandom, $urandom}, 1'($urandom), FIT_W'($urandom), bin);
    endtask

    task automatic wait_idle();
        frag_ch.valid <= 1'b0;
        @(posedge clk);
        while (reads_waiting != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        windows_used++;
    endtask

    // Mostly nondecreasing stamps with random content; when noisy, some
    // stamps step backwards or jump anywhere in the 64-bit range.
    task automatic run_phase(input logic [TS_W-1:0] base, input int step_max,
                             input int read_span, input int count, input int qualify_pct,
                             input bit noisy);
        logic [TS_W-1:0]  stamp;
        logic             det;
        logic [FIT_W-1:0] fit;
        int               pick;
        stamp = base;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0)
            begin
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 99) < 25)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    send_read(READ_BIN_W'($urandom_range(0, read_span)));
                end
                else
                begin
                    send_read(READ_BIN_W'($urandom));
                end
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (noisy && pick < 6)
                begin
                    stamp = stamp - TS_W'($urandom_range(1, 3 * step_max + 1));
                end
                else if (noisy && pick < 10)
                begin
                    stamp = {$urandom, $urandom};
                end
                else
                begin
                    stamp = stamp + TS_W'($urandom_range(0, step_max));
                end
                if ($urandom_range(0, 99) < qualify_pct)
                begin
                    det = 1'b1;
                    fit = FIT_QUALIFY;
                end
                else
                begin
                    det = 1'($urandom);
                    fit = FIT_W'($urandom);
                end
                send_fragment(stamp, det, fit);
            end
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        frag_ch.valid        = 1'b0;
        frag_ch.action       = ACTION_FRAGMENT;
        frag_ch.timestamp_ns = '0;
        frag_ch.in_detector  = 1'b0;
        frag_ch.fit_type     = '0;
        frag_ch.read_bin     = '0;
        fragments_sent       = 0;
        reads_sent           = 0;
        windows_used         = 1;
        quiet_cycles         = 0;
        gaps_on              = 1'b1;
        no_idle              = 1'b0;
        hold_req             = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the window at its reset value.
        send_fragment(64'd0, 1'b1, FIT_QUALIFY);
        send_fragment(64'd0, 1'b1, FIT_QUALIFY);          // equal stamps land in bin 0
        send_fragment(64'd5, 1'b0, FIT_QUALIFY);          // outside the detector
        send_fragment(64'd5, 1'b1, 8'hFF);                // wrong fit type
        send_fragment(64'd1000, 1'b1, FIT_QUALIFY);       // exactly at the window edge
        send_fragment(64'd1001, 1'b1, FIT_QUALIFY);       // retires the oldest slots
        send_fragment(64'd500, 1'b1, FIT_QUALIFY);        // stamp going backwards
        send_read(READ_BIN_W'(0));
        send_read(READ_BIN_W'(1000));
        send_read(READ_BIN_W'(1));
        send_word(ACTION_READ, '1, 1'b1, FIT_QUALIFY, '1);
        send_fragment('1, 1'b1, FIT_QUALIFY);
        send_fragment(64'd3, 1'b1, FIT_QUALIFY);          // difference wraps through zero
        send_fragment(64'd3, 1'b1, 8'h00);
        send_fragment(64'h8000_0000_0000_0000, 1'b0, 8'h80);
        send_read(READ_BIN_W'(4));
        send_read(READ_BIN_W'(0));
        wait_idle();

        write_window('0);
        run_phase({$urandom, $urandom}, 1, 3, 100, 70, 1'b1);
        wait_idle();

        // The result side holds off for a long stretch while reads keep
        // coming, so the unit fills up and stalls its input.
        write_window(WINDOW_W'(37));
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        repeat (24) send_read(READ_BIN_W'($urandom_range(0, 40)));
        gaps_on  = 1'b1;
        run_phase({$urandom, $urandom}, 15, 40, 100, 70, 1'b1);
        wait_idle();

        // A window wider than the bin range keeps slots whose difference
        // is past the last bin.
        write_window(WINDOW_W'(70000));
        run_phase({$urandom, $urandom}, 4000, 8000, 100, 65, 1'b1);
        wait_idle();

        write_window(WINDOW_RESET);
        run_phase(64'hFFFF_FFFF_FFFF_F000, 200, 1000, 100, 70, 1'b1);
        wait_idle();

        // Widest window with steady stamps: the slots fill and overflow.
        no_idle = 1'b1;
        write_window('1);
        run_phase({$urandom, $urandom}, 60, 2000, 120, 90, 1'b0);
        wait_idle();

        $display("Covered %0d fragment words and %0d read words over %0d window settings,",
                 fragments_sent, reads_sent, windows_used);
        $display("including stamp wrap, backward stamps, a long result stall and slot overflow.");
        if (mismatches == 0 && reads_waiting == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
